### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; every use sits in a module that has i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define GBTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define GBTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gbte_pkg.sv
`default_nettype none

package gbte_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_BACK   = 3'd1,
        ACT_MOVE   = 3'd2,
        ACT_SEEK   = 3'd3,
        ACT_HOME   = 3'd4,
        ACT_END    = 3'd5,
        ACT_READ   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam logic [7:0] NEWLINE = 8'h0A;

endpackage

`default_nettype wire

### rtl/core/gbte_ram.sv
`default_nettype none

// Simple dual-port RAM: one write, one read per cycle, registered read data.
module gbte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/gap_buffer_text_editor.sv
// Gap buffer text editor with a cursor, CAPACITY bytes of text in one RAM.
// Request channel: drive start with i_action and its operands; the item is
// taken at the clock edge where start is high and busy is low. busy stays
// high until the result has been produced.
// Result channel: o_valid is high for exactly one cycle with o_char_out,
// o_cursor, o_text_length and o_status. The receiver cannot stall it; a
// result not taken in that cycle is gone. A new start is taken in that same
// strobe cycle.
// After the accepting edge the item sits in S_SETUP, where insert,
// backspace, an unused action and a read out of range finish; a read in
// range goes on to S_READ for its one RAM read; move, seek and line
// home / end go on to the S_STEP copy loop, which ends once all bytes to
// move are crossed or, for home / end, a newline stops the scan.
// A new item is taken only once the previous one is done; cursor moves copy
// one byte per cycle through the RAM (read one byte ahead, write the previous
// one), so the single read port and write port set the move rate.
// Reset (synchronous, active low) empties the text and homes the cursor;
// no clearing pass is needed, since no byte outside the text is ever read.
`default_nettype none

`include "assert_macros.svh"

module gap_buffer_text_editor
    import gbte_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  i_action,
    input  wire logic        [7:0]  i_char_in,
    input  wire logic signed [11:0] i_move_distance,
    input  wire logic        [10:0] i_target_position,
    input  wire logic        [9:0]  i_read_index,
    output logic                    o_valid,
    output logic             [7:0]  o_char_out,
    output logic             [10:0] o_cursor,
    output logic             [10:0] o_text_length,
    output logic             [1:0]  o_status
);

    // counter width holds 0..CAPACITY, address width 0..CAPACITY-1,
    // compare width covers counters and the 12-bit operands
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = ((CW > 12) ? CW : 12) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_X = SW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_STEP
    } t_state;

    t_state        r_state,  n_state;
    logic [CW-1:0] r_before, n_before;
    logic [CW-1:0] r_after,  n_after;
    t_action       r_act,    n_act;
    logic [7:0]    r_ch,     n_ch;
    logic [11:0]   r_dist,   n_dist;
    logic [10:0]   r_target, n_target;
    logic [9:0]    r_ridx,   n_ridx;
    logic          r_right,  n_right;
    logic          r_scan,   n_scan;
    logic [CW-1:0] r_remain, n_remain;
    logic [AW-1:0] r_src,    n_src;
    logic [AW-1:0] r_dst,    n_dst;
    logic          r_pend,   n_pend;
    logic          r_valid,  n_valid;
    logic [7:0]    r_char,   n_char;
    t_status       r_status, n_status;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    gbte_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // setup arithmetic; the comparisons run at compare width
    logic [CW-1:0] len_c;
    logic [SW-1:0] b_x, a_x, len_x, mag_x, tgt_x, seek_x, ridx_x, gap_x, raddr_x;
    logic [11:0]   dist_mag;
    logic [CW-1:0] left_dst, right_src;
    logic          stop;

    always_comb begin
        len_c     = r_before + r_after;
        b_x       = SW'(r_before);
        a_x       = SW'(r_after);
        len_x     = SW'(len_c);
        dist_mag  = r_dist[11] ? (~r_dist + 12'd1) : r_dist;
        mag_x     = SW'(dist_mag);
        tgt_x     = SW'(r_target);
        seek_x    = (tgt_x > len_x) ? len_x : tgt_x;
        ridx_x    = SW'(r_ridx);
        gap_x     = CAP_X - len_x;
        raddr_x   = (ridx_x < b_x) ? ridx_x : (ridx_x + gap_x);
        right_src = CAP_C - r_after;
        left_dst  = right_src - CW'(1);
    end

    // scan hit: the byte just read is a newline, so the cursor stops here
    assign stop = r_pend && r_scan && (ram_rdata == NEWLINE);

    always_comb begin
        n_state  = r_state;
        n_before = r_before;
        n_after  = r_after;
        n_act    = r_act;
        n_ch     = r_ch;
        n_dist   = r_dist;
        n_target = r_target;
        n_ridx   = r_ridx;
        n_right  = r_right;
        n_scan   = r_scan;
        n_remain = r_remain;
        n_src    = r_src;
        n_dst    = r_dst;
        n_pend   = 1'b0;
        n_valid  = 1'b0;
        n_char   = r_char;
        n_status = r_status;

        ram_we    = 1'b0;
        ram_waddr = r_dst;
        ram_wdata = ram_rdata;
        ram_raddr = r_src;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act    = t_action'(i_action);
                    n_ch     = i_char_in;
                    n_dist   = i_move_distance;
                    n_target = i_target_position;
                    n_ridx   = i_read_index;
                    n_state  = S_SETUP;
                end
            end

            S_SETUP: begin
                // default: finish now with an ok result
                n_valid  = 1'b1;
                n_char   = 8'd0;
                n_status = ST_OK;
                n_state  = S_IDLE;
                n_scan   = 1'b0;
                n_right  = 1'b0;
                n_remain = '0;
                unique case (r_act)
                    ACT_INSERT: begin
                        if (len_x >= CAP_X) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_before[AW-1:0];
                            ram_wdata = r_ch;
                            n_before  = r_before + CW'(1);
                        end
                    end
                    ACT_BACK: begin
                        if (r_before != '0) begin
                            n_before = r_before - CW'(1);
                        end
                    end
                    ACT_MOVE: begin
                        n_valid = 1'b0;
                        n_state = S_STEP;
                        if (r_dist[11]) begin
                            n_remain = CW'((mag_x > b_x) ? b_x : mag_x);
                        end else begin
                            n_right  = 1'b1;
                            n_remain = CW'((mag_x > a_x) ? a_x : mag_x);
                        end
                    end
                    ACT_SEEK: begin
                        n_valid = 1'b0;
                        n_state = S_STEP;
                        if (seek_x >= b_x) begin
                            n_right  = 1'b1;
                            n_remain = CW'(seek_x - b_x);
                        end else begin
                            n_remain = CW'(b_x - seek_x);
                        end
                    end
                    ACT_HOME: begin
                        n_valid  = 1'b0;
                        n_state  = S_STEP;
                        n_scan   = 1'b1;
                        n_remain = r_before;
                    end
                    ACT_END: begin
                        n_valid  = 1'b0;
                        n_state  = S_STEP;
                        n_scan   = 1'b1;
                        n_right  = 1'b1;
                        n_remain = r_after;
                    end
                    ACT_READ: begin
                        if (ridx_x >= len_x) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_valid   = 1'b0;
                            ram_raddr = raddr_x[AW-1:0];
                            n_state   = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
                // copy pointers: source on the far side of the gap from the cursor
                if (n_right) begin
                    n_src = right_src[AW-1:0];
                    n_dst = r_before[AW-1:0];
                end else begin
                    n_src = AW'(r_before - CW'(1));
                    n_dst = left_dst[AW-1:0];
                end
            end

            S_READ: begin
                n_valid  = 1'b1;
                n_char   = ram_rdata;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end

            S_STEP: begin
                // commit the byte read last cycle across the gap
                if (r_pend && !stop) begin
                    ram_we = 1'b1;
                    if (r_right) begin
                        n_dst    = r_dst + AW'(1);
                        n_before = r_before + CW'(1);
                        n_after  = r_after - CW'(1);
                    end else begin
                        n_dst    = r_dst - AW'(1);
                        n_before = r_before - CW'(1);
                        n_after  = r_after + CW'(1);
                    end
                end
                // read one byte ahead
                if (!stop && (r_remain != '0)) begin
                    n_pend   = 1'b1;
                    n_remain = r_remain - CW'(1);
                    n_src    = r_right ? (r_src + AW'(1)) : (r_src - AW'(1));
                end
                if (stop || (r_remain == '0)) begin
                    n_pend   = 1'b0;
                    n_valid  = 1'b1;
                    n_char   = 8'd0;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_before <= '0;
            r_after  <= '0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
            r_char   <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_before <= n_before;
            r_after  <= n_after;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_char   <= n_char;
        end
    end

    // operand and copy-loop registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_ch     <= n_ch;
        r_dist   <= n_dist;
        r_target <= n_target;
        r_ridx   <= n_ridx;
        r_right  <= n_right;
        r_scan   <= n_scan;
        r_remain <= n_remain;
        r_src    <= n_src;
        r_dst    <= n_dst;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_char_out    = r_char;
    assign o_cursor      = 11'(r_before);
    assign o_text_length = 11'(len_c);
    assign o_status      = r_status;

    `GBTE_ASSERT_IMPL(a_len_le_cap, 1'b1, (SW'(r_before) + SW'(r_after)) <= CAP_X, "text too long")
    `GBTE_ASSERT_NEXT(a_strobe_pulse, r_valid, !r_valid, "result strobe longer than one cycle")
    `GBTE_ASSERT_IMPL(a_idle_quiet, r_state == S_IDLE, !r_pend && !ram_we, "RAM busy while idle")
    `GBTE_ASSERT_IMPL(a_pend_in_step, r_pend, r_state == S_STEP, "read in flight outside copy loop")

endmodule

`default_nettype wire

### bench/gap_buffer_text_editor_checker.sv
`default_nettype none

module gap_buffer_text_editor_checker
    import gbte_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic        [2:0]  i_action,
    input  wire logic        [7:0]  i_char_in,
    input  wire logic signed [11:0] i_move_distance,
    input  wire logic        [10:0] i_target_position,
    input  wire logic        [9:0]  i_read_index,
    input  wire logic               i_valid,
    input  wire logic        [7:0]  i_res_char,
    input  wire logic        [10:0] i_res_cursor,
    input  wire logic        [10:0] i_res_length,
    input  wire logic        [1:0]  i_res_status,
    output int                      o_error_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [7:0]  chr;
        logic [10:0] cur;
        logic [10:0] len;
        t_status     stat;
    } t_edit_outcome;

    // text shadow: left part at the bottom, right part at the top
    logic [7:0]    text_mem [CAPACITY];
    int            left_len;
    int            right_len;
    t_edit_outcome expected_outcomes [$];

    function automatic void nudge_left();
        if (left_len > 0) begin
            text_mem[CAPACITY - right_len - 1] = text_mem[left_len - 1];
            left_len--;
            right_len++;
        end
    endfunction

    function automatic void nudge_right();
        if (right_len > 0) begin
            text_mem[left_len] = text_mem[CAPACITY - right_len];
            left_len++;
            right_len--;
        end
    endfunction

    function automatic void shift_by(input int offset);
        int steps;
        if (offset > 0) begin
            steps = (offset > right_len) ? right_len : offset;
            repeat (steps) nudge_right();
        end else if (offset < 0) begin
            steps = (-offset > left_len) ? left_len : -offset;
            repeat (steps) nudge_left();
        end
    endfunction

    function automatic t_edit_outcome apply_edit(
        input logic [2:0]         act,
        input logic [7:0]         ch,
        input logic signed [11:0] hop,
        input logic [10:0]        tgt,
        input logic [9:0]         ridx
    );
        t_edit_outcome res;
        int            total;
        int            goal;
        res.chr  = '0;
        res.stat = ST_OK;
        total    = left_len + right_len;
        case (act)
            ACT_INSERT: begin
                if (total >= CAPACITY) begin
                    res.stat = ST_FULL;
                end else begin
                    text_mem[left_len] = ch;
                    left_len++;
                end
            end
            ACT_BACK: if (left_len > 0) left_len--;
            ACT_MOVE: shift_by(int'(hop));
            ACT_SEEK: begin
                goal = (int'(tgt) > total) ? total : int'(tgt);
                shift_by(goal - left_len);
            end
            ACT_HOME: begin
                while (left_len > 0 && text_mem[left_len - 1] != NEWLINE) nudge_left();
            end
            ACT_END: begin
                while (right_len > 0 && text_mem[CAPACITY - right_len] != NEWLINE)
                    nudge_right();
            end
            ACT_READ: begin
                if (int'(ridx) >= total)
                    res.stat = ST_RANGE;
                else if (int'(ridx) < left_len)
                    res.chr = text_mem[ridx];
                else
                    res.chr = text_mem[CAPACITY - right_len + (int'(ridx) - left_len)];
            end
            default: ;
        endcase
        res.cur = 11'(left_len);
        res.len = 11'(left_len + right_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_edit_outcome want;
        if (!i_rst_n) begin
            left_len      = 0;
            right_len     = 0;
            o_error_count = 0;
            expected_outcomes.delete();
        end else begin
            // the strobe in this cycle belongs to an earlier item: check first
            if (i_valid) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result: cursor %0d, length %0d",
                           i_res_cursor, i_res_length);
                    o_error_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_res_char !== want.chr) begin
                        $error("char_out: expected %0d, actual %0d", want.chr, i_res_char);
                        o_error_count++;
                    end
                    if (i_res_cursor !== want.cur) begin
                        $error("cursor: expected %0d, actual %0d", want.cur, i_res_cursor);
                        o_error_count++;
                    end
                    if (i_res_length !== want.len) begin
                        $error("text_length: expected %0d, actual %0d", want.len,
                               i_res_length);
                        o_error_count++;
                    end
                    if (i_res_status !== want.stat) begin
                        $error("status: expected %0d, actual %0d", want.stat, i_res_status);
                        o_error_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_outcomes.push_back(apply_edit(i_action, i_char_in, i_move_distance,
                                                       i_target_position, i_read_index));
        end
        o_pending = expected_outcomes.size();
    end

endmodule

`default_nettype wire

### bench/gap_buffer_text_editor_test.sv
`default_nettype none

// Stimulus and verdict for the gap buffer editor. Prediction and comparison
// live in the checker instance next to the block.
module gap_buffer_text_editor_test
    import gbte_pkg::*;
();

    localparam int         CAPACITY    = 1024;
    // Worst case is a full-length cursor move per item plus the longest sender
    // gap; at most about 2200 items at that cost, taken five times over.
    localparam int         CYCLE_LIMIT = 12_000_000;
    // Action code outside the enum; the block must treat it as a no-op.
    localparam logic [2:0] ACT_UNUSED  = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic        [2:0]  i_action;
    logic        [7:0]  i_char_in;
    logic signed [11:0] i_move_distance;
    logic        [10:0] i_target_position;
    logic        [9:0]  i_read_index;
    logic               o_valid;
    logic        [7:0]  o_char_out;
    logic        [10:0] o_cursor;
    logic        [10:0] o_text_length;
    logic        [1:0]  o_status;

    int error_count;
    int pending;
    int cycle_count = 0;
    // Text length as last reported by the block; steers the stimulus only.
    int text_len    = 0;
    // Idle bursts come in stretches; this flag turns them on and off.
    bit idle_mode   = 1'b1;

    gap_buffer_text_editor #(.CAPACITY(CAPACITY)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_char_in         (i_char_in),
        .i_move_distance   (i_move_distance),
        .i_target_position (i_target_position),
        .i_read_index      (i_read_index),
        .o_valid           (o_valid),
        .o_char_out        (o_char_out),
        .o_cursor          (o_cursor),
        .o_text_length     (o_text_length),
        .o_status          (o_status)
    );

    gap_buffer_text_editor_checker #(.CAPACITY(CAPACITY)) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_action          (i_action),
        .i_char_in         (i_char_in),
        .i_move_distance   (i_move_distance),
        .i_target_position (i_target_position),
        .i_read_index      (i_read_index),
        .i_valid           (o_valid),
        .i_res_char        (o_char_out),
        .i_res_cursor      (o_cursor),
        .i_res_length      (o_text_length),
        .i_res_status      (o_status),
        .o_error_count     (error_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (o_valid) text_len <= o_text_length;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gap_buffer_text_editor: mismatch");
            $finish;
        end
    end

    // Present one item and hold it until the edge that takes it. Called at a
    // rising edge; returns at the accepting edge with start still high, so a
    // back-to-back item just overwrites the fields in the next call.
    task automatic issue_edit(
        input logic [2:0]         act,
        input logic [7:0]         ch,
        input logic signed [11:0] hop,
        input logic [10:0]        tgt,
        input logic [9:0]         ridx
    );
        start             <= 1'b1;
        i_action          <= act;
        i_char_in         <= ch;
        i_move_distance   <= hop;
        i_target_position <= tgt;
        i_read_index      <= ridx;
        // busy read right after the edge is its value before the edge
        do @(posedge i_clk); while (busy);
    endtask

    // Sender idle burst; skipped in the quiet tail and in no-idle stretches.
    task automatic maybe_idle(input bit quiet);
        if ($urandom_range(39) == 0) idle_mode = !idle_mode;
        if (!quiet && idle_mode && $urandom_range(2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    // One random item. ins_pct / back_pct weight inserts and backspaces; the
    // rest is spread over moves, seeks, line scans, reads and the unused code.
    task automatic random_edit(input int ins_pct, input int back_pct);
        int                 roll;
        int                 pick;
        int                 tmp;
        logic [2:0]         act;
        logic [7:0]         ch;
        logic signed [11:0] hop;
        logic [10:0]        tgt;
        logic [9:0]         ridx;

        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            act = ACT_INSERT;
        end else if (roll < ins_pct + back_pct) begin
            act = ACT_BACK;
        end else begin
            pick = $urandom_range(30);
            if (pick == 0)       act = ACT_UNUSED;
            else if (pick <= 6)  act = ACT_MOVE;
            else if (pick <= 12) act = ACT_SEEK;
            else if (pick <= 17) act = ACT_HOME;
            else if (pick <= 22) act = ACT_END;
            else                 act = ACT_READ;
        end

        // plenty of newlines so line scans stay short and varied
        ch = ($urandom_range(5) == 0) ? NEWLINE : 8'($urandom);

        // mostly short hops; long moves are slow, so they stay a minority
        roll = $urandom_range(99);
        if (roll < 70) begin
            tmp = int'($urandom_range(64)) - 32;
            hop = 12'(tmp);
        end else if (roll < 85) begin
            tmp = int'($urandom_range(2048)) - 1024;
            hop = 12'(tmp);
        end else if (roll < 95) begin
            case ($urandom_range(3))
                0:       hop = -12'sd2048;
                1:       hop = 12'sd2047;
                2:       hop = -12'sd1024;
                default: hop = 12'sd1024;
            endcase
        end else begin
            hop = 12'($urandom);
        end

        roll = $urandom_range(99);
        if (roll < 70) begin
            tgt = 11'($urandom_range(text_len));
        end else if (roll < 90) begin
            tgt = 11'($urandom);
        end else begin
            case ($urandom_range(2))
                0:       tgt = '0;
                1:       tgt = '1;
                default: tgt = 11'(CAPACITY);
            endcase
        end

        // reads mostly hit the text; the rest probe the out-of-range path
        if (text_len > 0 && $urandom_range(99) < 80)
            ridx = 10'($urandom_range(text_len - 1));
        else
            ridx = 10'($urandom);

        issue_edit(act, ch, hop, tgt, ridx);
    endtask

    initial begin
        int fill_items;

        start             <= 1'b0;
        i_rst_n           <= 1'b0;
        i_action          <= ACT_INSERT;
        i_char_in         <= '0;
        i_move_distance   <= '0;
        i_target_position <= '0;
        i_read_index      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: read, backspace, move, both scans and the unused code on an empty
        // text first, then a short two-line text "\0 \xff \n a b" to exercise the scans and clamps.
        issue_edit(ACT_READ,   8'h00, 12'sd0,    11'd0,    10'd0);    // read with no text
        issue_edit(ACT_BACK,   8'h00, 12'sd0,    11'd0,    10'd0);    // backspace at start
        issue_edit(ACT_MOVE,   8'h00, -12'sd5,   11'd0,    10'd0);    // move, nothing to cross
        issue_edit(ACT_HOME,   8'h00, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_END,    8'h00, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_UNUSED, 8'hFF, 12'sd7,    11'd5,    10'd3);    // no-op code
        issue_edit(ACT_INSERT, 8'h00, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_INSERT, 8'hFF, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_INSERT, NEWLINE, 12'sd0,  11'd0,    10'd0);
        issue_edit(ACT_INSERT, 8'h61, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_INSERT, 8'h62, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_HOME,   8'h00, 12'sd0,    11'd0,    10'd0);    // stops after newline
        issue_edit(ACT_HOME,   8'h00, 12'sd0,    11'd0,    10'd0);    // already at line start
        issue_edit(ACT_MOVE,   8'h00, -12'sd2048, 11'd0,   10'd0);    // clamps at 0
        issue_edit(ACT_END,    8'h00, 12'sd0,    11'd0,    10'd0);    // stops before newline
        issue_edit(ACT_MOVE,   8'h00, 12'sd2047, 11'd0,    10'd0);    // clamps at length
        issue_edit(ACT_SEEK,   8'h00, 12'sd0,    11'h7FF,  10'd0);    // seek past the end
        issue_edit(ACT_SEEK,   8'h00, 12'sd0,    11'd0,    10'd0);
        issue_edit(ACT_READ,   8'h00, 12'sd0,    11'd0,    10'd1);    // right of the gap
        issue_edit(ACT_MOVE,   8'h00, 12'sd1024, 11'd0,    10'd0);
        issue_edit(ACT_MOVE,   8'h00, -12'sd1024, 11'd0,   10'd0);
        issue_edit(ACT_SEEK,   8'h00, 12'sd0,    11'd2,    10'd0);
        issue_edit(ACT_READ,   8'h00, 12'sd0,    11'd0,    10'd4);    // right of the gap
        issue_edit(ACT_READ,   8'h00, 12'sd0,    11'd0,    10'h3FF);  // out of range
        issue_edit(ACT_BACK,   8'h00, 12'sd0,    11'd0,    10'd0);

        // Mixed editing on a growing text.
        repeat (550) begin
            maybe_idle(1'b0);
            random_edit(45, 8);
        end

        // Fill the store; text_len lags one item, so a full insert may land
        // here already, which is welcome.
        fill_items = 0;
        while (text_len < CAPACITY && fill_items < 1400) begin
            maybe_idle(1'b0);
            random_edit(92, 2);
            fill_items++;
        end

        // At capacity: dropped inserts mixed with moves, scans and reads.
        repeat (40) begin
            maybe_idle(1'b0);
            random_edit(50, 0);
        end

        // Shrink again; the tail runs without sender gaps.
        for (int i = 0; i < 180; i++) begin
            maybe_idle(i >= 80);
            random_edit(20, 40);
        end

        start <= 1'b0;
        // the checker counts the last item at its accepting edge; look only after that edge
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a little slack for any stray strobe after the last result
        repeat (12) @(posedge i_clk);

        if (error_count == 0 && pending == 0) begin
            $display("gap_buffer_text_editor: match");
        end else begin
            $display("gap_buffer_text_editor: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
